// File: sv/hbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbm_pkg
// Types and constants shared by the NMT slave and heartbeat monitor modules.
// ----------------------------------------------------------------------------
package hbm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_NODE_ID = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HB_PERIOD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_ID     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_FIRST  = 3'd3;

    localparam logic [6:0] ST_BOOT    = 7'd0;
    localparam logic [6:0] ST_STOPPED = 7'd4;
    localparam logic [6:0] ST_OPER    = 7'd5;
    localparam logic [6:0] ST_PREOP   = 7'd127;

    localparam logic [3:0] EV_HEARTBEAT  = 4'd0;
    localparam logic [3:0] EV_STATE      = 4'd1;
    localparam logic [3:0] EV_RESET_NODE = 4'd2;
    localparam logic [3:0] EV_RESET_COMM = 4'd3;
    localparam logic [3:0] EV_SYNC       = 4'd4;
    localparam logic [3:0] EV_SDO        = 4'd5;
    localparam logic [3:0] EV_PDO        = 4'd6;
    localparam logic [3:0] EV_LOST       = 4'd7;
    localparam logic [3:0] EV_RECOVERED  = 4'd8;

    localparam logic [10:0] NMT_COB_ID  = 11'h000;
    localparam logic [10:0] HB_BASE     = 11'h700;
    localparam logic [10:0] SDO_RX_BASE = 11'h600;

    localparam logic [7:0] CMD_START      = 8'd1;
    localparam logic [7:0] CMD_STOP       = 8'd2;
    localparam logic [7:0] CMD_PREOP      = 8'd128;
    localparam logic [7:0] CMD_RESET_NODE = 8'd129;
    localparam logic [7:0] CMD_RESET_COMM = 8'd130;

    typedef enum logic [2:0] {
        CLS_TICK,
        CLS_NMT,
        CLS_SYNC,
        CLS_SDO,
        CLS_HB,
        CLS_PDO
    } hbm_cls_t;

    typedef enum logic [1:0] {
        NMT_NONE,
        NMT_GO,
        NMT_RESET_NODE,
        NMT_RESET_COMM
    } hbm_nmt_act_t;

    typedef struct packed {
        hbm_cls_t     cls;
        logic         hb_frame;
        hbm_nmt_act_t act;
        logic [6:0]   go_state;
        logic [7:0]   hb_node;
        logic [31:0]  now;
    } hbm_cmd_t;

    typedef struct packed {
        logic [6:0]  own_node_id;
        logic [15:0] beat_period;
        logic [10:0] sync_id;
    } hbm_cfg_t;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [10:0] tx_cob_id;
        logic [6:0]  tx_byte;
        logic [6:0]  nmt_now;
        logic [7:0]  watched_node;
    } hbm_res_t;

endpackage

// File: sv/hbm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbm_front
// Accepts input transfers and classifies each into a command for the queue.
// ----------------------------------------------------------------------------
module hbm_front (
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              in_kind,
    input  logic [hbm_pkg::IN_DATA_W-1:0]     in_data,
    input  hbm_pkg::hbm_cfg_t                 cfg,
    input  logic                              q_full,
    output logic                              push,
    output hbm_pkg::hbm_cmd_t                 cmd
);

    logic [10:0] can_id;
    logic [3:0]  frame_len;
    logic [7:0]  byte_zero;
    logic [7:0]  byte_one;
    logic [31:0] tick_time_ms;
    logic        is_hb;
    logic        target_ok;

    assign can_id       = in_data[10:0];
    assign frame_len    = in_data[14:11];
    assign byte_zero    = in_data[22:15];
    assign byte_one     = in_data[30:23];
    assign tick_time_ms = in_data[62:31];

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    assign is_hb     = (can_id[10:7] == hbm_pkg::HB_BASE[10:7]);
    assign target_ok = (byte_one == 8'd0) || (byte_one == {1'b0, cfg.own_node_id});

    always_comb
    begin
        cmd          = '0;
        cmd.now      = tick_time_ms;
        cmd.hb_frame = !in_kind && is_hb;
        cmd.hb_node  = {1'b0, can_id[6:0]};
        cmd.act      = hbm_pkg::NMT_NONE;
        cmd.go_state = hbm_pkg::ST_PREOP;

        priority if (in_kind)
        begin
            cmd.cls = hbm_pkg::CLS_TICK;
        end
        else if (can_id == hbm_pkg::NMT_COB_ID)
        begin
            cmd.cls = hbm_pkg::CLS_NMT;
        end
        else if (can_id == cfg.sync_id && frame_len <= 4'd1)
        begin
            cmd.cls = hbm_pkg::CLS_SYNC;
        end
        else if (can_id == (hbm_pkg::SDO_RX_BASE | {4'b0000, cfg.own_node_id}))
        begin
            cmd.cls = hbm_pkg::CLS_SDO;
        end
        else if (is_hb)
        begin
            cmd.cls = hbm_pkg::CLS_HB;
        end
        else
        begin
            cmd.cls = hbm_pkg::CLS_PDO;
        end

        if (frame_len >= 4'd2 && target_ok)
        begin
            unique case (byte_zero)
                hbm_pkg::CMD_START:
                begin
                    cmd.act      = hbm_pkg::NMT_GO;
                    cmd.go_state = hbm_pkg::ST_OPER;
                end
                hbm_pkg::CMD_STOP:
                begin
                    cmd.act      = hbm_pkg::NMT_GO;
                    cmd.go_state = hbm_pkg::ST_STOPPED;
                end
                hbm_pkg::CMD_PREOP:
                begin
                    cmd.act      = hbm_pkg::NMT_GO;
                    cmd.go_state = hbm_pkg::ST_PREOP;
                end
                hbm_pkg::CMD_RESET_NODE: cmd.act = hbm_pkg::NMT_RESET_NODE;
                hbm_pkg::CMD_RESET_COMM: cmd.act = hbm_pkg::NMT_RESET_COMM;
                default:                 cmd.act = hbm_pkg::NMT_NONE;
            endcase
        end
    end

endmodule

// File: sv/hbm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbm_queue
// Two-entry command queue between the classifying front and the sequencer.
// ----------------------------------------------------------------------------
module hbm_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hbm_pkg::hbm_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output hbm_pkg::hbm_cmd_t head
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    hbm_pkg::hbm_cmd_t entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [PTR_W:0]    count_reg;
    logic [PTR_W:0]    count_next;
    logic              do_pop;

    assign full   = (count_reg == (PTR_W + 1)'(DEPTH));
    assign valid  = (count_reg != '0);
    assign head   = entry_reg[rd_ptr_reg];
    assign do_pop = pop && valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: sv/hbm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbm_back
// Result sequencer: holds NMT and consumer state and emits at most one result
// a cycle unless stalled, keeping one in hand so that the final one carries last.
// ----------------------------------------------------------------------------
module hbm_back #(
    parameter int CONSUMER_SLOTS = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  hbm_pkg::hbm_cfg_t                     cfg,
    input  logic [hbm_pkg::CFG_DATA_W-1:0]        slot_cfg [CONSUMER_SLOTS],
    input  logic [CONSUMER_SLOTS-1:0]             slot_clr,
    input  logic                                  q_valid,
    input  hbm_pkg::hbm_cmd_t                     q_cmd,
    output logic                                  q_pop,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output hbm_pkg::hbm_res_t                     out_res,
    output logic                                  out_last
);

    localparam int IDX_W = (CONSUMER_SLOTS > 1) ? $clog2(CONSUMER_SLOTS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CONSUMER_SLOTS - 1);

    typedef enum logic [2:0] {
        P_IDLE,
        P_BOOT_HB,
        P_BOOT_CHG,
        P_MAIN,
        P_SLOT,
        P_DONE
    } phase_t;

    phase_t                    phase_reg, phase_next;
    hbm_pkg::hbm_cmd_t         cmd_reg, cmd_next;
    logic                      main_done_reg, main_done_next;
    logic [IDX_W-1:0]          slot_idx_reg, slot_idx_next;
    logic [6:0]                nmt_mode_reg, nmt_mode_next;
    logic                      boot_pending_reg, boot_pending_next;
    logic [31:0]               cur_time_reg, cur_time_next;
    logic [31:0]               last_hb_reg, last_hb_next;
    logic [31:0]               last_seen_reg [CONSUMER_SLOTS];
    logic [31:0]               last_seen_next [CONSUMER_SLOTS];
    logic [CONSUMER_SLOTS-1:0] seen_reg, seen_next;
    logic [CONSUMER_SLOTS-1:0] lost_reg, lost_next;
    logic                      pend_valid_reg, pend_valid_next;
    hbm_pkg::hbm_res_t         pend_reg, pend_next;
    logic                      out_valid_reg, out_valid_next;
    hbm_pkg::hbm_res_t         out_res_reg, out_res_next;
    logic                      out_last_reg, out_last_next;

    logic [10:0]                    hb_cob;
    logic [hbm_pkg::CFG_DATA_W-1:0] sl_cfg;
    logic [15:0]                    sl_to;
    logic                           sl_on;
    logic [7:0]                     sl_node;
    logic [31:0]                    sl_elapsed;
    logic                           sl_lose;
    logic                           sl_hit;
    logic                           is_tick;
    logic                           hb_due;
    logic                           stopped_skip;
    logic                           gen_valid;
    hbm_pkg::hbm_res_t              gen_res;
    logic                           need_push;
    logic                           advance;
    logic                           item_end;

    assign hb_cob       = hbm_pkg::HB_BASE | {4'b0000, cfg.own_node_id};
    assign sl_cfg       = slot_cfg[slot_idx_reg];
    assign sl_to        = sl_cfg[15:0];
    assign sl_on        = (sl_to != 16'd0);
    assign sl_node      = sl_on ? sl_cfg[23:16] : 8'd0;
    assign sl_elapsed   = cur_time_reg - last_seen_reg[slot_idx_reg];
    assign sl_lose      = (sl_node != 8'd0) && sl_on && seen_reg[slot_idx_reg]
                          && !lost_reg[slot_idx_reg] && (sl_elapsed > {16'd0, sl_to});
    assign sl_hit       = sl_on && (sl_node == cmd_reg.hb_node);
    assign is_tick      = (cmd_reg.cls == hbm_pkg::CLS_TICK);
    assign hb_due       = (cfg.beat_period != 16'd0)
                          && ((cmd_reg.now - last_hb_reg) >= {16'd0, cfg.beat_period});
    assign stopped_skip = !is_tick && (cmd_reg.cls != hbm_pkg::CLS_NMT)
                          && (nmt_mode_reg == hbm_pkg::ST_STOPPED);

    always_comb
    begin
        gen_valid       = 1'b0;
        gen_res         = '0;
        gen_res.nmt_now = nmt_mode_reg;

        unique case (phase_reg)
            P_BOOT_HB:
            begin
                gen_valid         = 1'b1;
                gen_res.event_res = hbm_pkg::EV_HEARTBEAT;
                gen_res.tx_cob_id = hb_cob;
                gen_res.tx_byte   = hbm_pkg::ST_BOOT;
                gen_res.nmt_now   = hbm_pkg::ST_BOOT;
            end
            P_BOOT_CHG:
            begin
                gen_valid         = 1'b1;
                gen_res.event_res = hbm_pkg::EV_STATE;
                gen_res.nmt_now   = hbm_pkg::ST_PREOP;
            end
            P_MAIN:
            begin
                if (!stopped_skip)
                begin
                    unique case (cmd_reg.cls)
                        hbm_pkg::CLS_TICK:
                        begin
                            if (hb_due)
                            begin
                                gen_valid         = 1'b1;
                                gen_res.event_res = hbm_pkg::EV_HEARTBEAT;
                                gen_res.tx_cob_id = hb_cob;
                                gen_res.tx_byte   = nmt_mode_reg;
                            end
                        end
                        hbm_pkg::CLS_NMT:
                        begin
                            unique case (cmd_reg.act)
                                hbm_pkg::NMT_GO:
                                begin
                                    if (cmd_reg.go_state != nmt_mode_reg)
                                    begin
                                        gen_valid         = 1'b1;
                                        gen_res.event_res = hbm_pkg::EV_STATE;
                                        gen_res.nmt_now   = cmd_reg.go_state;
                                    end
                                end
                                hbm_pkg::NMT_RESET_NODE:
                                begin
                                    gen_valid         = 1'b1;
                                    gen_res.event_res = hbm_pkg::EV_RESET_NODE;
                                end
                                hbm_pkg::NMT_RESET_COMM:
                                begin
                                    gen_valid         = 1'b1;
                                    gen_res.event_res = hbm_pkg::EV_RESET_COMM;
                                end
                                hbm_pkg::NMT_NONE:
                                begin
                                    gen_valid = 1'b0;
                                end
                                default:
                                begin
                                    gen_valid = 1'b0;
                                end
                            endcase
                        end
                        hbm_pkg::CLS_SYNC:
                        begin
                            gen_valid         = 1'b1;
                            gen_res.event_res = hbm_pkg::EV_SYNC;
                        end
                        hbm_pkg::CLS_SDO:
                        begin
                            gen_valid         = 1'b1;
                            gen_res.event_res = hbm_pkg::EV_SDO;
                        end
                        hbm_pkg::CLS_PDO:
                        begin
                            gen_valid         = 1'b1;
                            gen_res.event_res = hbm_pkg::EV_PDO;
                        end
                        default:
                        begin
                            gen_valid = 1'b0;
                        end
                    endcase
                end
            end
            P_SLOT:
            begin
                if (is_tick)
                begin
                    if (sl_lose)
                    begin
                        gen_valid            = 1'b1;
                        gen_res.event_res    = hbm_pkg::EV_LOST;
                        gen_res.watched_node = sl_node;
                    end
                end
                else if (sl_hit && lost_reg[slot_idx_reg])
                begin
                    gen_valid            = 1'b1;
                    gen_res.event_res    = hbm_pkg::EV_RECOVERED;
                    gen_res.watched_node = sl_node;
                end
            end
            default:
            begin
                gen_valid = 1'b0;
            end
        endcase
    end

    assign item_end  = (phase_reg == P_DONE);
    assign need_push = pend_valid_reg && (gen_valid || item_end);
    assign advance   = !need_push || !out_valid_reg || out_ready;

    always_comb
    begin
        phase_next        = phase_reg;
        cmd_next          = cmd_reg;
        main_done_next    = main_done_reg;
        slot_idx_next     = slot_idx_reg;
        nmt_mode_next     = nmt_mode_reg;
        boot_pending_next = boot_pending_reg;
        cur_time_next     = cur_time_reg;
        last_hb_next      = last_hb_reg;
        last_seen_next    = last_seen_reg;
        seen_next         = seen_reg;
        lost_next         = lost_reg;
        pend_valid_next   = pend_valid_reg;
        pend_next         = pend_reg;
        out_valid_next    = out_valid_reg;
        out_res_next      = out_res_reg;
        out_last_next     = out_last_reg;
        q_pop             = 1'b0;

        if (advance)
        begin
            unique case (phase_reg)
                P_BOOT_HB:
                begin
                    nmt_mode_next     = hbm_pkg::ST_BOOT;
                    boot_pending_next = 1'b0;
                    phase_next        = P_BOOT_CHG;
                end
                P_BOOT_CHG:
                begin
                    nmt_mode_next = hbm_pkg::ST_PREOP;
                    phase_next    = main_done_reg ? P_DONE : P_MAIN;
                end
                P_MAIN:
                begin
                    main_done_next = 1'b1;
                    phase_next     = P_DONE;
                    if (stopped_skip)
                    begin
                        if (cmd_reg.hb_frame)
                        begin
                            phase_next = P_SLOT;
                        end
                    end
                    else
                    begin
                        unique case (cmd_reg.cls)
                            hbm_pkg::CLS_TICK:
                            begin
                                cur_time_next = cmd_reg.now;
                                if (hb_due)
                                begin
                                    last_hb_next = cmd_reg.now;
                                end
                                phase_next = P_SLOT;
                            end
                            hbm_pkg::CLS_NMT:
                            begin
                                if (cmd_reg.act == hbm_pkg::NMT_GO)
                                begin
                                    nmt_mode_next = cmd_reg.go_state;
                                end
                                else if (cmd_reg.act == hbm_pkg::NMT_RESET_COMM)
                                begin
                                    phase_next = P_BOOT_HB;
                                end
                            end
                            hbm_pkg::CLS_HB:
                            begin
                                phase_next = P_SLOT;
                            end
                            default:
                            begin
                                phase_next = P_DONE;
                            end
                        endcase
                    end
                end
                P_SLOT:
                begin
                    if (is_tick)
                    begin
                        if (sl_lose)
                        begin
                            lost_next[slot_idx_reg] = 1'b1;
                        end
                    end
                    else if (sl_hit)
                    begin
                        last_seen_next[slot_idx_reg] = cur_time_reg;
                        seen_next[slot_idx_reg]      = 1'b1;
                        lost_next[slot_idx_reg]      = 1'b0;
                    end
                    if (slot_idx_reg == IDX_LAST)
                    begin
                        phase_next = P_DONE;
                    end
                    else
                    begin
                        slot_idx_next = slot_idx_reg + 1'b1;
                    end
                end
                default:
                begin
                    if (q_valid)
                    begin
                        q_pop          = 1'b1;
                        cmd_next       = q_cmd;
                        main_done_next = 1'b0;
                        slot_idx_next  = '0;
                        phase_next     = boot_pending_reg ? P_BOOT_HB : P_MAIN;
                    end
                    else
                    begin
                        phase_next = P_IDLE;
                    end
                end
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance && need_push)
        begin
            out_valid_next = 1'b1;
            out_res_next   = pend_reg;
            out_last_next  = item_end;
        end

        if (advance)
        begin
            if (gen_valid)
            begin
                pend_valid_next = 1'b1;
                pend_next       = gen_res;
            end
            else if (item_end)
            begin
                pend_valid_next = 1'b0;
            end
        end

        seen_next = seen_next & ~slot_clr;
        lost_next = lost_next & ~slot_clr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= P_IDLE;
            cmd_reg          <= '0;
            main_done_reg    <= 1'b0;
            slot_idx_reg     <= '0;
            nmt_mode_reg     <= hbm_pkg::ST_PREOP;
            boot_pending_reg <= 1'b1;
            cur_time_reg     <= '0;
            last_hb_reg      <= '0;
            for (int i = 0; i < CONSUMER_SLOTS; i++)
            begin
                last_seen_reg[i] <= '0;
            end
            seen_reg         <= '0;
            lost_reg         <= '0;
            pend_valid_reg   <= 1'b0;
            pend_reg         <= '0;
            out_valid_reg    <= 1'b0;
            out_res_reg      <= '0;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            cmd_reg          <= cmd_next;
            main_done_reg    <= main_done_next;
            slot_idx_reg     <= slot_idx_next;
            nmt_mode_reg     <= nmt_mode_next;
            boot_pending_reg <= boot_pending_next;
            cur_time_reg     <= cur_time_next;
            last_hb_reg      <= last_hb_next;
            last_seen_reg    <= last_seen_next;
            seen_reg         <= seen_next;
            lost_reg         <= lost_next;
            pend_valid_reg   <= pend_valid_next;
            pend_reg         <= pend_next;
            out_valid_reg    <= out_valid_next;
            out_res_reg      <= out_res_next;
            out_last_reg     <= out_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_last  = out_last_reg;

endmodule

// File: sv/nmt_slave_heartbeat_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmt_slave_heartbeat_monitor
// NMT slave with heartbeat producer and heartbeat consumer.
// ----------------------------------------------------------------------------
// Each input transfer is classified on arrival and placed in a two-entry
// queue, so the input side keeps accepting while earlier items are still
// producing results. The result sequencer emits at most one result per cycle
// while the output is not stalled. For each item it carries out the main
// action, steps through the consumer slots one by one for ticks and heartbeat
// frames, plays the boot-up pair after reset and on reset communication, and
// closes the item while it takes the next one.
// Results of one input leave as a run of transfers closed by tlast.
module nmt_slave_heartbeat_monitor #(
    parameter int CONSUMER_SLOTS = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [hbm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hbm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // can_id[10:0], frame_len[14:11], byte_zero[22:15], byte_one[30:23],
    // tick_time_ms[62:31], zero fill[63]
    input  logic [hbm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // kind[0]
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // event_res[3:0], tx_cob_id[14:4], tx_byte[21:15], nmt_now[28:22],
    // watched_node[36:29], zero fill[39:37]
    output logic [hbm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                               m_axis_tlast
);

    logic [6:0]                     own_node_id_reg;
    logic [15:0]                    hb_period_reg;
    logic [10:0]                    sync_id_reg;
    logic [hbm_pkg::CFG_DATA_W-1:0] slot_cfg_reg [CONSUMER_SLOTS];
    logic [CONSUMER_SLOTS-1:0]      slot_wr;
    hbm_pkg::hbm_cfg_t              cfg;

    logic                           q_push;
    logic                           q_full;
    logic                           q_pop;
    logic                           q_valid;
    hbm_pkg::hbm_cmd_t              front_cmd;
    hbm_pkg::hbm_cmd_t              q_head;
    hbm_pkg::hbm_res_t              res;

    for (genvar i = 0; i < CONSUMER_SLOTS; i++)
    begin : g_slot_wr
        assign slot_wr[i] = cfg_wr_en
                            && (cfg_index == hbm_pkg::REG_SLOT_FIRST + hbm_pkg::CFG_IDX_W'(i));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_node_id_reg <= 7'd1;
            hb_period_reg   <= 16'd0;
            sync_id_reg     <= 11'd128;
            for (int i = 0; i < CONSUMER_SLOTS; i++)
            begin
                slot_cfg_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en && cfg_index == hbm_pkg::REG_OWN_NODE_ID)
            begin
                own_node_id_reg <= cfg_data[6:0];
            end
            if (cfg_wr_en && cfg_index == hbm_pkg::REG_HB_PERIOD)
            begin
                hb_period_reg <= cfg_data[15:0];
            end
            if (cfg_wr_en && cfg_index == hbm_pkg::REG_SYNC_ID)
            begin
                sync_id_reg <= cfg_data[10:0];
            end
            for (int i = 0; i < CONSUMER_SLOTS; i++)
            begin
                if (slot_wr[i])
                begin
                    slot_cfg_reg[i] <= cfg_data;
                end
            end
        end
    end

    assign cfg.own_node_id = own_node_id_reg;
    assign cfg.beat_period = hb_period_reg;
    assign cfg.sync_id     = sync_id_reg;

    hbm_front u_front (
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_kind  (s_axis_tuser),
        .in_data  (s_axis_tdata),
        .cfg      (cfg),
        .q_full   (q_full),
        .push     (q_push),
        .cmd      (front_cmd)
    );

    hbm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    hbm_back #(
        .CONSUMER_SLOTS (CONSUMER_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .slot_cfg  (slot_cfg_reg),
        .slot_clr  (slot_wr),
        .q_valid   (q_valid),
        .q_cmd     (q_head),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, res.watched_node, res.nmt_now, res.tx_byte,
                           res.tx_cob_id, res.event_res};

    a_nmt_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[28:22] == hbm_pkg::ST_BOOT
                           || m_axis_tdata[28:22] == hbm_pkg::ST_STOPPED
                           || m_axis_tdata[28:22] == hbm_pkg::ST_OPER
                           || m_axis_tdata[28:22] == hbm_pkg::ST_PREOP))
        else $error("result carries an NMT state outside the defined set");

    a_hb_cob: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[3:0] == hbm_pkg::EV_HEARTBEAT)
        |-> (m_axis_tdata[14:4] == (hbm_pkg::HB_BASE | {4'b0000, own_node_id_reg})))
        else $error("heartbeat result with an identifier not matching the node id");

    a_no_tx_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[3:0] != hbm_pkg::EV_HEARTBEAT)
        |-> (m_axis_tdata[21:4] == '0))
        else $error("non-heartbeat result carries transmit fields");

endmodule

// File: test/tb_nmt_slave_heartbeat_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nmt_slave_heartbeat_monitor
// Self-checking bench for the NMT slave with heartbeat producer and consumer.
// A scoreboard class keeps its own copy of the NMT state, the producer timer
// and the consumer slots, and works out the results of every accepted input
// transfer. Each result transfer is checked field by field against the
// oldest expectation. A short directed run covers every command, every event
// and the special frames; random phases with fresh register settings follow,
// mostly ticks, watched heartbeats and addressed NMT commands, while both
// stream sides stall at random outside one steady phase.
// ----------------------------------------------------------------------------
module tb_nmt_slave_heartbeat_monitor;

    localparam int SLOTS        = 4;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 32;
    localparam int GAP_PERCENT  = 12;
    localparam int REPORT_CAP   = 50;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 67;

    localparam logic [hbm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [3:0]  NMT_MIN_LEN  = 4'd2;
    localparam logic [3:0]  SYNC_MAX_LEN = 4'd1;
    localparam logic [3:0]  MAX_LEN      = 4'd8;
    localparam logic [10:0] HB_SPAN      = 11'd127;
    localparam logic [10:0] SYNC_RESET   = 11'd128;

    typedef struct {
        hbm_pkg::hbm_res_t res;
        logic              last;
    } nmt_result_t;

    class nmt_scoreboard;
        logic [6:0]  own_id;
        logic [15:0] hb_period;
        logic [10:0] sync_cob;
        logic [23:0] slot_cfg[SLOTS];
        logic [6:0]  mode;
        bit          boot_due;
        logic [31:0] now_ms;
        logic [31:0] last_hb_ms;
        logic [31:0] seen_at[SLOTS];
        bit          seen[SLOTS];
        bit          lost[SLOTS];
        nmt_result_t due_results[$];
        int          errors;

        function new();
            own_id     = 7'd1;
            hb_period  = '0;
            sync_cob   = SYNC_RESET;
            mode       = hbm_pkg::ST_PREOP;
            boot_due   = 1'b1;
            now_ms     = '0;
            last_hb_ms = '0;
            errors     = 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_cfg[i] = '0;
                seen_at[i]  = '0;
                seen[i]     = 1'b0;
                lost[i]     = 1'b0;
            end
        endfunction

        function void apply_reg(logic [hbm_pkg::CFG_IDX_W-1:0] idx,
                                logic [hbm_pkg::CFG_DATA_W-1:0] val);
            int k;
            case (idx)
                hbm_pkg::REG_OWN_NODE_ID: own_id = val[6:0];
                hbm_pkg::REG_HB_PERIOD:   hb_period = val[15:0];
                hbm_pkg::REG_SYNC_ID:     sync_cob = val[10:0];
                default:
                begin
                    if (idx != REG_UNUSED)
                    begin
                        k           = int'(idx - hbm_pkg::REG_SLOT_FIRST);
                        slot_cfg[k] = val;
                        seen[k]     = 1'b0;
                        lost[k]     = 1'b0;
                    end
                end
            endcase
        endfunction

        function logic [7:0] watched(int i);
            return (slot_cfg[i][15:0] == '0) ? 8'd0 : slot_cfg[i][23:16];
        endfunction

        function logic [10:0] hb_cob();
            return hbm_pkg::HB_BASE + {4'd0, own_id};
        endfunction

        function void add(logic [3:0] ev, logic [10:0] cob, logic [6:0] sent,
                          logic [7:0] node);
            nmt_result_t r;
            r.res.event_res    = ev;
            r.res.tx_cob_id    = cob;
            r.res.tx_byte      = sent;
            r.res.nmt_now      = mode;
            r.res.watched_node = node;
            r.last             = 1'b0;
            due_results.push_back(r);
        endfunction

        function void set_mode(logic [6:0] st);
            if (mode != st)
            begin
                mode = st;
                add(hbm_pkg::EV_STATE, '0, '0, '0);
            end
        endfunction

        function void boot_up();
            mode = hbm_pkg::ST_BOOT;
            add(hbm_pkg::EV_HEARTBEAT, hb_cob(), hbm_pkg::ST_BOOT, '0);
            set_mode(hbm_pkg::ST_PREOP);
        endfunction

        function void heard(logic [10:0] id);
            logic [10:0] off;
            logic [7:0]  node;
            off  = id - hbm_pkg::HB_BASE;
            node = off[7:0];
            for (int i = 0; i < SLOTS; i++)
            begin
                if (watched(i) == node && slot_cfg[i][15:0] != '0)
                begin
                    seen_at[i] = now_ms;
                    seen[i]    = 1'b1;
                    if (lost[i])
                    begin
                        lost[i] = 1'b0;
                        add(hbm_pkg::EV_RECOVERED, '0, '0, node);
                    end
                end
            end
        endfunction

        function void note_item(logic kind, logic [10:0] id, logic [3:0] len,
                                logic [7:0] cmd, logic [7:0] target, logic [31:0] t);
            int          n_old;
            bit          is_hb;
            logic [31:0] gap;
            logic [7:0]  node;
            nmt_result_t tail;
            n_old = due_results.size();
            is_hb = (id >= hbm_pkg::HB_BASE) && (id <= hbm_pkg::HB_BASE + HB_SPAN);
            if (boot_due)
            begin
                boot_due = 1'b0;
                boot_up();
            end
            if (kind)
            begin
                now_ms = t;
                gap    = t - last_hb_ms;
                if (hb_period != '0 && gap >= {16'd0, hb_period})
                begin
                    last_hb_ms = t;
                    add(hbm_pkg::EV_HEARTBEAT, hb_cob(), mode, '0);
                end
                for (int i = 0; i < SLOTS; i++)
                begin
                    node = watched(i);
                    gap  = t - seen_at[i];
                    if (node != '0 && slot_cfg[i][15:0] != '0 && seen[i] && !lost[i]
                        && gap > {16'd0, slot_cfg[i][15:0]})
                    begin
                        lost[i] = 1'b1;
                        add(hbm_pkg::EV_LOST, '0, '0, node);
                    end
                end
            end
            else if (id == hbm_pkg::NMT_COB_ID)
            begin
                if (len >= NMT_MIN_LEN && (target == '0 || target == {1'b0, own_id}))
                begin
                    case (cmd)
                        hbm_pkg::CMD_START:      set_mode(hbm_pkg::ST_OPER);
                        hbm_pkg::CMD_STOP:       set_mode(hbm_pkg::ST_STOPPED);
                        hbm_pkg::CMD_PREOP:      set_mode(hbm_pkg::ST_PREOP);
                        hbm_pkg::CMD_RESET_NODE: add(hbm_pkg::EV_RESET_NODE, '0, '0, '0);
                        hbm_pkg::CMD_RESET_COMM:
                        begin
                            add(hbm_pkg::EV_RESET_COMM, '0, '0, '0);
                            boot_up();
                        end
                        default: ;
                    endcase
                end
            end
            else if (mode == hbm_pkg::ST_STOPPED)
            begin
                if (is_hb)
                    heard(id);
            end
            else if (id == sync_cob && len <= SYNC_MAX_LEN)
                add(hbm_pkg::EV_SYNC, '0, '0, '0);
            else if (id == hbm_pkg::SDO_RX_BASE + {4'd0, own_id})
                add(hbm_pkg::EV_SDO, '0, '0, '0);
            else if (is_hb)
                heard(id);
            else
                add(hbm_pkg::EV_PDO, '0, '0, '0);
            if (due_results.size() > n_old)
            begin
                tail      = due_results.pop_back();
                tail.last = 1'b1;
                due_results.push_back(tail);
            end
        endfunction

        task report(string what);
            if (errors < REPORT_CAP)
                $display("MISMATCH: %s", what);
            errors++;
        endtask

        task compare(string name, int unsigned got, int unsigned want);
            if (got != want)
                report($sformatf("%s got %0d, expected %0d", name, got, want));
        endtask

        task check_result(logic [hbm_pkg::OUT_DATA_W-1:0] data, logic tl);
            nmt_result_t want;
            if (due_results.size() == 0)
            begin
                report($sformatf("result %h arrived with nothing expected", data));
                return;
            end
            want = due_results.pop_front();
            compare("event_res", data[3:0], want.res.event_res);
            compare("tx_cob_id", data[14:4], want.res.tx_cob_id);
            compare("tx_byte", data[21:15], want.res.tx_byte);
            compare("nmt_now", data[28:22], want.res.nmt_now);
            compare("watched_node", data[36:29], want.res.watched_node);
            compare("last", tl, want.last);
        endtask
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_wr_en;
    logic [hbm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [hbm_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [hbm_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic                           s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [hbm_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           m_axis_tlast;

    nmt_scoreboard sb = new();
    bit            steady = 1'b0;
    int            cycles = 0;
    logic [31:0]   tick_ms = '0;

    nmt_slave_heartbeat_monitor #(
        .CONSUMER_SLOTS(SLOTS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk)
        m_axis_tready <= steady || ($urandom_range(0, 99) >= GAP_PERCENT);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task send(logic kind, logic [10:0] id, logic [3:0] len, logic [7:0] b0,
              logic [7:0] b1, logic [31:0] t);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < GAP_PERCENT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {1'b0, t, b1, b0, len, id};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_item(kind, id, len, b0, b1, t);
    endtask

    task send_frame(logic [10:0] id, logic [3:0] len, logic [7:0] b0, logic [7:0] b1);
        send(1'b0, id, len, b0, b1, $urandom);
    endtask

    task send_nmt(logic [7:0] cmd, logic [7:0] target, logic [3:0] len);
        send_frame(hbm_pkg::NMT_COB_ID, len, cmd, target);
    endtask

    task send_tick(logic [31:0] t);
        send(1'b1, 11'($urandom), 4'($urandom_range(0, 8)), 8'($urandom), 8'($urandom), t);
    endtask

    // Stop sending and wait until the block has nothing left to do.
    task settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task write_regs(logic [6:0] own, logic [15:0] period, logic [10:0] sync_cob,
                    logic [23:0] s0, logic [23:0] s1, logic [23:0] s2, logic [23:0] s3);
        logic [hbm_pkg::CFG_DATA_W-1:0] vals[8];
        logic [hbm_pkg::CFG_IDX_W-1:0]  idx;
        vals[hbm_pkg::REG_OWN_NODE_ID]       = {17'd0, own};
        vals[hbm_pkg::REG_HB_PERIOD]         = {8'd0, period};
        vals[hbm_pkg::REG_SYNC_ID]           = {13'd0, sync_cob};
        vals[hbm_pkg::REG_SLOT_FIRST]        = s0;
        vals[hbm_pkg::REG_SLOT_FIRST + 3'd1] = s1;
        vals[hbm_pkg::REG_SLOT_FIRST + 3'd2] = s2;
        vals[hbm_pkg::REG_SLOT_FIRST + 3'd3] = s3;
        vals[REG_UNUSED]                     = 24'($urandom);
        for (int i = 0; i < 8; i++)
        begin
            idx = 3'(i);
            @(negedge clk);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[i];
            sb.apply_reg(idx, vals[i]);
        end
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function logic [23:0] random_slot();
        logic [7:0]  node;
        logic [15:0] limit;
        int          r;
        r = $urandom_range(0, 9);
        if (r == 0)
            node = '0;
        else if (r == 1)
            node = 8'($urandom_range(128, 255));
        else
            node = 8'($urandom_range(1, 127));
        r = $urandom_range(0, 9);
        if (r == 0)
            limit = '0;
        else if (r == 1)
            limit = 16'hFFFF;
        else
            limit = 16'($urandom_range(1, 40));
        return {node, limit};
    endfunction

    task random_phase(int p);
        logic [6:0]  own;
        logic [15:0] period;
        logic [10:0] sync_cob;
        own      = (p == 0) ? 7'd1 : (p == 1) ? 7'd127 : 7'($urandom_range(1, 127));
        period   = (p == 2) ? 16'd0 : (p == 3) ? 16'hFFFF : 16'($urandom_range(1, 40));
        sync_cob = (p == 0) ? 11'd0 : (p == 1) ? 11'h7FF
                 : (p == 4) ? hbm_pkg::SDO_RX_BASE + {4'd0, own} : 11'($urandom);
        write_regs(own, period, sync_cob, random_slot(), random_slot(), random_slot(),
                   random_slot());
        if (p == PHASES - 1)
            tick_ms = 32'hFFFF_FF00 + 32'($urandom_range(0, 200));
    endtask

    task random_item();
        int          r;
        int          k;
        logic [7:0]  cmd;
        logic [7:0]  target;
        logic [3:0]  len;
        logic [10:0] id;
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            if ($urandom_range(0, 9) == 0)
                tick_ms = $urandom;
            else
                tick_ms = tick_ms + $urandom_range(0, 25);
            send_tick(tick_ms);
        end
        else if (r < 60)
        begin
            k = $urandom_range(0, SLOTS - 1);
            if ($urandom_range(0, 4) == 0)
                id = hbm_pkg::HB_BASE + 11'($urandom_range(0, 127));
            else
                id = hbm_pkg::HB_BASE + {4'd0, sb.slot_cfg[k][22:16]};
            send_frame(id, 4'($urandom_range(0, 8)), 8'($urandom), 8'($urandom));
        end
        else if (r < 75)
        begin
            k = $urandom_range(0, 99);
            if (k < 30)
                cmd = hbm_pkg::CMD_START;
            else if (k < 55)
                cmd = hbm_pkg::CMD_STOP;
            else if (k < 75)
                cmd = hbm_pkg::CMD_PREOP;
            else if (k < 85)
                cmd = hbm_pkg::CMD_RESET_NODE;
            else if (k < 90)
                cmd = hbm_pkg::CMD_RESET_COMM;
            else
                cmd = 8'($urandom);
            k = $urandom_range(0, 99);
            target = (k < 45) ? 8'd0 : (k < 90) ? {1'b0, sb.own_id} : 8'($urandom);
            len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 1))
                                              : 4'($urandom_range(2, 8));
            send_nmt(cmd, target, len);
        end
        else if (r < 85)
            send_frame(sb.sync_cob, 4'($urandom_range(0, 8)), 8'($urandom), 8'($urandom));
        else if (r < 90)
            send_frame(hbm_pkg::SDO_RX_BASE + {4'd0, sb.own_id}, 4'($urandom_range(0, 8)),
                       8'($urandom), 8'($urandom));
        else
            send_frame(11'($urandom), 4'($urandom_range(0, 8)), 8'($urandom), 8'($urandom));
    endtask

    initial
    begin
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: the first transfer is preceded by the boot-up pair.
        send_frame(11'h181, 4'd8, 8'h00, 8'h00);
        send_tick(32'd0);
        settle();
        write_regs(7'd5, 16'd10, 11'h080, {8'd7, 16'd20}, {8'd9, 16'hFFFF},
                   {8'd200, 16'd30}, {8'd0, 16'd50});

        send_nmt(hbm_pkg::CMD_START, 8'd5, 4'd1);
        send_nmt(hbm_pkg::CMD_START, 8'd6, 4'd2);
        send_nmt(8'h55, 8'd0, 4'd2);
        send_nmt(hbm_pkg::CMD_START, 8'd5, MAX_LEN);
        send_nmt(hbm_pkg::CMD_START, 8'd0, 4'd2);
        send_frame(11'h080, 4'd0, 8'h00, 8'h00);
        send_frame(11'h080, 4'd2, 8'h00, 8'h00);
        send_frame(11'h605, 4'd8, 8'h40, 8'h00);
        send_frame(11'h707, 4'd1, 8'h05, 8'h00);
        send_tick(32'd5);
        send_tick(32'd30);
        send_frame(11'h707, 4'd1, 8'h05, 8'h00);
        send_nmt(hbm_pkg::CMD_STOP, 8'd0, 4'd2);
        send_frame(11'h181, 4'd8, 8'hFF, 8'hFF);
        send_frame(11'h080, 4'd0, 8'h00, 8'h00);
        send_frame(11'h709, 4'd1, 8'h7F, 8'h00);
        send_nmt(hbm_pkg::CMD_PREOP, 8'd5, 4'd2);
        send_nmt(hbm_pkg::CMD_RESET_NODE, 8'd0, 4'd2);
        send_nmt(hbm_pkg::CMD_RESET_COMM, 8'd5, 4'd2);
        send_tick(32'hFFFF_FFFF);
        send_tick(32'd0);
        send_frame(11'h7FF, MAX_LEN, 8'hFF, 8'hFF);
        send_frame(11'h77F, 4'd0, 8'h00, 8'h00);
        send_frame(11'h700, 4'd1, 8'h00, 8'h00);

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            random_phase(p);
            steady = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_item();
        end
        steady = 1'b0;

        settle();
        if (sb.errors == 0 && sb.due_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
